// ===== hw/rtl/pfr_pkg.sv =====
// Shared types and constants for the page frame buffer refresh unit.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

  // Command codes carried on the cmd port.
  typedef enum logic [2:0] {
    CMD_FILL    = 3'd0,
    CMD_BORDER  = 3'd1,
    CMD_PIXEL   = 3'd2,
    CMD_REFRESH = 3'd3,
    CMD_NEXT    = 3'd4
  } cmd_t;

  // Header slots sent ahead of each page's data bytes.
  localparam int unsigned HDR_SLOTS     = 4;
  localparam int unsigned SLOT_PAGE_CMD = 0;
  localparam int unsigned SLOT_PAGE_NUM = 1;
  localparam int unsigned SLOT_COL_LO   = 2;
  localparam int unsigned SLOT_COL_HI   = 3;

  // Fixed byte values of the panel stream and of the frame contents.
  localparam logic [7:0] BYTE_PAGE_CMD   = 8'h22;
  localparam logic [7:0] BYTE_COL_LO     = 8'h00;
  localparam logic [7:0] BYTE_COL_HI     = 8'h10;
  localparam logic [7:0] BYTE_BLANK      = 8'hFF;
  localparam logic [7:0] BYTE_TOP_ROW    = 8'h7F;
  localparam logic [7:0] BYTE_BOTTOM_ROW = 8'hFE;
  localparam logic [7:0] BYTE_ALL_LIT    = 8'h00;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep_start;
    logic sweep_fill;
    logic sweep_border;
    logic pix_load;
    logic pix_read;
    logic pix_write;
    logic rf_start;
    logic rf_emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic rf_active;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_ctrl.sv =====
// Controller state machine that sequences sweeps, pixel updates and refresh bytes.
`timescale 1ns / 1ps
`default_nettype none

module pfr_ctrl
  import pfr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [2:0]   cmd,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         ctl,
  output logic              busy
);

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_FILL      = 7'b0000100,
    ST_BORDER    = 7'b0001000,
    ST_PIX_READ  = 7'b0010000,
    ST_PIX_WRITE = 7'b0100000,
    ST_EMIT      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  // State register; reset starts the clearing pass over the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_CLEAR: begin
        ctl.sweep_fill = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (cmd)
            CMD_FILL: begin
              ctl.sweep_start = 1'b1;
              state_next      = ST_FILL;
            end
            CMD_BORDER: begin
              ctl.sweep_start = 1'b1;
              state_next      = ST_BORDER;
            end
            CMD_PIXEL: begin
              ctl.pix_load = 1'b1;
              state_next   = ST_PIX_READ;
            end
            CMD_REFRESH: begin
              ctl.rf_start = 1'b1;
            end
            CMD_NEXT: begin
              if (status.rf_active) begin
                state_next = ST_EMIT;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_FILL: begin
        ctl.sweep_fill = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_BORDER: begin
        ctl.sweep_border = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_PIX_READ: begin
        ctl.pix_read = 1'b1;
        state_next   = ST_PIX_WRITE;
      end
      ST_PIX_WRITE: begin
        ctl.pix_write = 1'b1;
        state_next    = ST_IDLE;
      end
      ST_EMIT: begin
        ctl.rf_emit = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_datapath.sv =====
// Datapath with the frame memory, sweep and refresh counters and output word registers.
`timescale 1ns / 1ps
`default_nettype none

module pfr_datapath
  import pfr_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [6:0]   x,
  input  wire logic [4:0]   y,
  input  wire ctrl_cmd_t    ctl,
  output ctrl_status_t      status,
  output logic [7:0]        spi_byte,
  output logic              data_mode,
  output logic              last_byte,
  output logic              strobe
);

  localparam int unsigned FRAME_BYTES = PAGES * COLUMNS;
  localparam int unsigned AW = $clog2(FRAME_BYTES);
  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam int unsigned SW = $clog2(COLUMNS + HDR_SLOTS);

  // Frame memory, one write port and one registered read port.
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          wr_en;

  // Sweep counters for clear, fill and border passes.
  logic [AW-1:0] sweep_addr;
  logic [CW-1:0] sweep_col;
  logic [PW-1:0] sweep_page;
  logic [7:0]    border_byte;

  // Pixel update registers.
  logic [AW-1:0] pix_addr;
  logic [7:0]    pix_mask;
  logic          pix_ok;
  logic [3:0]    pix_page_wide;
  logic [PW-1:0] pix_page;
  logic [AW:0]   pix_addr_wide;
  logic          pix_in_range;

  // Refresh position.
  logic          rf_active;
  logic [PW-1:0] rf_page;
  logic [SW-1:0] rf_slot;
  logic [AW:0]   rf_addr_wide;
  logic          rf_last;
  logic [7:0]    emit_byte;
  logic          emit_data;

  // Pixel address and mask from the command word.
  assign pix_page_wide = 4'(PAGES - 1) - {2'b00, y[4:3]};
  assign pix_page      = pix_page_wide[PW-1:0];
  assign pix_in_range  = (9'(x) < 9'(COLUMNS)) && ({2'b00, y[4:3]} < 4'(PAGES));
  assign pix_addr_wide = (AW+1)'(pix_page) * (AW+1)'(COLUMNS) + (AW+1)'(x);

  always_ff @(posedge clk) begin
    if (ctl.pix_load) begin
      pix_addr <= pix_addr_wide[AW-1:0];
      pix_mask <= 8'h80 >> y[2:0];
      pix_ok   <= pix_in_range;
    end
  end

  // Border byte for the current sweep position.
  always_comb begin
    border_byte = BYTE_BLANK;
    if (sweep_page == PW'(PAGES - 1)) begin
      border_byte = border_byte & BYTE_TOP_ROW;
    end
    if (sweep_page == '0) begin
      border_byte = border_byte & BYTE_BOTTOM_ROW;
    end
    if ((sweep_col == '0) || (sweep_col == CW'(COLUMNS - 1))) begin
      border_byte = BYTE_ALL_LIT;
    end
  end

  // Sweep counters advance once per written byte.
  always_ff @(posedge clk) begin
    if (rst || ctl.sweep_start) begin
      sweep_addr <= '0;
      sweep_col  <= '0;
      sweep_page <= '0;
    end else if (ctl.sweep_fill || ctl.sweep_border) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_col == CW'(COLUMNS - 1)) begin
        sweep_col  <= '0;
        sweep_page <= sweep_page + 1'b1;
      end else begin
        sweep_col <= sweep_col + 1'b1;
      end
    end
  end

  assign status.sweep_last = (sweep_addr == AW'(FRAME_BYTES - 1));
  assign status.rf_active  = rf_active;

  // Memory port selection.
  assign rf_addr_wide = (AW+1)'(rf_page) * (AW+1)'(COLUMNS) + (AW+1)'(rf_slot)
                        - (AW+1)'(HDR_SLOTS);
  assign rd_addr = ctl.pix_read ? pix_addr : rf_addr_wide[AW-1:0];
  assign wr_en   = ctl.sweep_fill || ctl.sweep_border || (ctl.pix_write && pix_ok);
  assign wr_addr = ctl.pix_write ? pix_addr : sweep_addr;
  assign wr_data = ctl.pix_write    ? (rd_data & ~pix_mask) :
                   ctl.sweep_border ? border_byte : BYTE_BLANK;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Byte selection for the current refresh slot.
  always_comb begin
    emit_data = 1'b0;
    case (rf_slot)
      SW'(SLOT_PAGE_CMD): emit_byte = BYTE_PAGE_CMD;
      SW'(SLOT_PAGE_NUM): emit_byte = 8'(rf_page);
      SW'(SLOT_COL_LO):   emit_byte = BYTE_COL_LO;
      SW'(SLOT_COL_HI):   emit_byte = BYTE_COL_HI;
      default: begin
        emit_byte = ~rd_data;
        emit_data = 1'b1;
      end
    endcase
  end

  assign rf_last = (rf_page == PW'(PAGES - 1)) && (rf_slot == SW'(COLUMNS + HDR_SLOTS - 1));

  // Refresh position and activity.
  always_ff @(posedge clk) begin
    if (rst || ctl.rf_start) begin
      rf_active <= ctl.rf_start && !rst;
      rf_page   <= '0;
      rf_slot   <= '0;
    end else if (ctl.rf_emit) begin
      if (rf_last) begin
        rf_active <= 1'b0;
        rf_page   <= '0;
        rf_slot   <= '0;
      end else if (rf_slot == SW'(COLUMNS + HDR_SLOTS - 1)) begin
        rf_slot <= '0;
        rf_page <= rf_page + 1'b1;
      end else begin
        rf_slot <= rf_slot + 1'b1;
      end
    end
  end

  // Output word registers, strobed for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.rf_emit;
    end
    if (ctl.rf_emit) begin
      spi_byte  <= emit_byte;
      data_mode <= emit_data;
      last_byte <= rf_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/page_framebuffer_refresh_unit.sv =====
// Top level of the page frame buffer refresh unit.
// Next byte: the word is registered from the emit state, which holds off new requests.
// Light pixel holds busy through a read then a write of the frame memory port.
// Fill and border sweep the frame with busy high, one byte per cycle on the write port.
// Reset runs a clearing pass that blanks the frame; busy is high.
// Start refresh and ignored commands leave the controller idle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module page_framebuffer_refresh_unit
  import pfr_pkg::*;
#(
  parameter int unsigned COLUMNS = 128,
  parameter int unsigned PAGES   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] cmd,
  input  wire logic [6:0] x,
  input  wire logic [4:0] y,
  output logic            strobe,
  output logic [7:0]      spi_byte,
  output logic            data_mode,
  output logic            last_byte
);

  ctrl_cmd_t    ctl;
  ctrl_status_t status;

  // Sequencing.
  pfr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .ctl    (ctl),
    .busy   (busy)
  );

  // Frame memory and stream generation.
  pfr_datapath #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .x         (x),
    .y         (y),
    .ctl       (ctl),
    .status    (status),
    .spi_byte  (spi_byte),
    .data_mode (data_mode),
    .last_byte (last_byte),
    .strobe    (strobe)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_checker.sv =====
// Port-level checker for the page frame buffer refresh unit and its bind.
`timescale 1ns / 1ps
`default_nettype none

module pfr_checker
  import pfr_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] cmd,
  input wire logic [6:0] x,
  input wire logic [4:0] y,
  input wire logic       strobe,
  input wire logic [7:0] spi_byte,
  input wire logic       data_mode,
  input wire logic       last_byte
);

  // Reset always starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // Every word answers a next-byte request accepted while the unit was idle.
  a_word_cause: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy && (cmd == CMD_NEXT), 2))
    else $error("word without a matching next-byte request");

  // Words never come on consecutive cycles.
  a_word_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("words on back-to-back cycles");

  // The final word of a refresh is a data byte.
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_byte) |-> data_mode)
    else $error("last word flagged as a command byte");

  // Command bytes are only the page header values.
  a_cmd_bytes: assert property (@(posedge clk) disable iff (rst)
    (strobe && !data_mode) |->
      ((spi_byte == BYTE_PAGE_CMD) || (spi_byte == BYTE_COL_HI) ||
       (spi_byte[7:3] == 5'd0)))
    else $error("unexpected command byte value");

endmodule

bind page_framebuffer_refresh_unit pfr_checker u_pfr_checker (.*);

`default_nettype wire
